@@ design/fbpa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the fixed block pool allocator: field widths, action, status and
// register codes, and the control word shared by the stack slots. No dependencies.
package fbpa_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 256;

    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // Request kinds.
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_USED = 2'd2;

    // Moves applied to every slot of the free index stack in the same cycle.
    typedef struct packed {
        logic load_init;  // slot i takes the value i
        logic shift_up;   // push: slot i takes slot i-1, slot 0 takes the pushed index
        logic shift_dn;   // pop: slot i takes slot i+1
    } slot_ctrl_t;

endpackage

@@ design/fbpa_slot.sv @@
`timescale 1ns / 1ps
// One slot of the shifting free index stack.
// Depends on fbpa_pkg for the slot control word.
module fbpa_slot #(
    parameter int IW   = 8,
    parameter int SLOT = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbpa_pkg::slot_ctrl_t   ctrl,
    input  logic [IW-1:0]          from_below,
    input  logic [IW-1:0]          from_above,
    output logic [IW-1:0]          value
);
    import fbpa_pkg::*;

    logic [IW-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= IW'(SLOT);
        end
        else
        begin
            priority if (ctrl.load_init)
            begin
                value_reg <= IW'(SLOT);
            end
            else if (ctrl.shift_up)
            begin
                value_reg <= from_below;
            end
            else if (ctrl.shift_dn)
            begin
                value_reg <= from_above;
            end
        end
    end

    assign value = value_reg;

endmodule

@@ design/fbpa_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for address offset / block size.
// Depends on fbpa_pkg for the address and size widths.
module fbpa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
    output logic                        done,
    output logic [fbpa_pkg::ADDR_W-1:0] quotient
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [ADDR_W-1:0] quo_reg;
    logic [SIZE_W-1:0] den_reg;

    logic [SIZE_W:0]   trial;
    logic              fits;
    logic [SIZE_W-1:0] rem_next;
    logic [ADDR_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[ADDR_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? SIZE_W'(trial - {1'b0, den_reg}) : trial[SIZE_W-1:0];
        quo_next = {quo_reg[ADDR_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ADDR_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ design/fixed_block_pool_allocator.sv @@
`timescale 1ns / 1ps
// Fixed block pool allocator. An allocate goes through a multiplier, then an adder; a free goes
// through a bit-serial divider; reset, unused and early-rejected requests go straight to the
// result. One request is in flight at a time; the next input is taken in the cycle after the
// result enters the output register. Reset (rst_n, asynchronous, active low) fills stack slot i
// with i, clears the top pointer and loads the register defaults base 0, block size 1, blocks
// in use 256.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbpa_pkg::IN_TDATA_W-1:0] s_tdata,   // [1:0] action, [33:2] block_address
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata   // [31:0] granted_address, [33:32] status
);
    import fbpa_pkg::*;

    // Index width for one block and pointer width that can also hold MAX_BLOCKS itself.
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_RESULT
    } state_t;

    // Configuration registers.
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] blocks_reg;

    // Control and datapath registers.
    state_t             state_reg;
    logic [CW-1:0]      top_reg;
    logic [IW-1:0]      idx_reg;
    logic [ADDR_W-1:0]  prod_reg;
    logic               res_grant_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // Request fields.
    logic [ACTION_W-1:0] in_action;
    logic [ADDR_W-1:0]   in_addr;
    logic                accept;

    // Derived values.
    logic [SIZE_W-1:0]  eff_size;
    logic [ADDR_W-1:0]  count32;
    logic [CW-1:0]      count;
    logic               exhausted;
    logic               below_base;
    logic [ADDR_W-1:0]  offset;
    logic               div_start;
    logic               div_done;
    logic [ADDR_W-1:0]  div_quot;
    logic               idx_outside;
    logic               out_load;

    // Stack slots: slot k holds free stack entry top + k.
    slot_ctrl_t         slot_ctrl;
    logic [IW-1:0]      slot_val [MAX_BLOCKS];

    assign in_action = s_tdata[ACTION_W-1:0];
    assign in_addr   = s_tdata[ACTION_W +: ADDR_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;

    // A block size of zero behaves as one byte.
    assign eff_size = (size_reg == '0) ? SIZE_W'(1) : size_reg;

    // The managed count is the register saturated at the stack depth.
    always_comb
    begin
        count32 = ADDR_W'(blocks_reg);
        if (count32 > ADDR_W'(MAX_BLOCKS))
        begin
            count32 = ADDR_W'(MAX_BLOCKS);
        end
    end
    assign count = count32[CW-1:0];

    assign exhausted   = (top_reg >= count);
    assign below_base  = (in_addr < base_reg);
    assign offset      = in_addr - base_reg;
    assign idx_outside = (div_quot >= count32);

    // The divider only runs for a free that passed the underflow and base checks.
    assign div_start = accept && (in_action == ACT_FREE) && (top_reg != '0) && !below_base;

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offset),
        .divisor  (eff_size),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Stack moves: a pop on a successful allocate, a push when a free's index is in range,
    // and a full refill on a reset request.
    always_comb
    begin
        slot_ctrl.load_init = accept && (in_action == ACT_RESET);
        slot_ctrl.shift_dn  = accept && (in_action == ACT_ALLOC) && !exhausted;
        slot_ctrl.shift_up  = (state_reg == S_DIV) && div_done && !idx_outside;
    end

    for (genvar k = 0; k < MAX_BLOCKS; k++)
    begin : g_slot
        logic [IW-1:0] below_val;
        logic [IW-1:0] above_val;

        if (k == 0)
        begin : g_first
            assign below_val = div_quot[IW-1:0];
        end
        else
        begin : g_mid_lo
            assign below_val = slot_val[k-1];
        end

        // Entries past the last slot are never read before being written again.
        if (k == MAX_BLOCKS - 1)
        begin : g_last
            assign above_val = '0;
        end
        else
        begin : g_mid_hi
            assign above_val = slot_val[k+1];
        end

        fbpa_slot #(
            .IW   (IW),
            .SLOT (k)
        ) u_slot (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (slot_ctrl),
            .from_below (below_val),
            .from_above (above_val),
            .value      (slot_val[k])
        );
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            size_reg   <= SIZE_W'(1);
            blocks_reg <= COUNT_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_BASE:   base_reg   <= cfg_wdata[ADDR_W-1:0];
                REG_BLOCK_BYTES: size_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_BLOCKS_USED: blocks_reg <= cfg_wdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // The pending result moves to the output register once that register is free.
    assign out_load = (state_reg == S_RESULT) && (!out_valid_reg || m_tready);

    // Sequencer, top pointer, datapath and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            top_reg        <= '0;
            idx_reg        <= '0;
            prod_reg       <= '0;
            res_grant_reg  <= 1'b0;
            res_status_reg <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= STAT_OK;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_grant_reg  <= 1'b0;
                        res_status_reg <= STAT_OK;
                        state_reg      <= S_RESULT;
                        unique case (in_action)
                            ACT_ALLOC:
                            begin
                                if (exhausted)
                                begin
                                    res_status_reg <= STAT_EXHAUSTED;
                                end
                                else
                                begin
                                    idx_reg       <= slot_val[0];
                                    top_reg       <= top_reg + 1'b1;
                                    res_grant_reg <= 1'b1;
                                    state_reg     <= S_MUL;
                                end
                            end
                            ACT_FREE:
                            begin
                                if (top_reg == '0)
                                begin
                                    res_status_reg <= STAT_UNDERFLOW;
                                end
                                else if (below_base)
                                begin
                                    res_status_reg <= STAT_OUTSIDE;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            ACT_RESET:
                            begin
                                top_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= ADDR_W'(eff_size) * ADDR_W'(idx_reg);
                    state_reg <= S_RESULT;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (idx_outside)
                        begin
                            res_status_reg <= STAT_OUTSIDE;
                        end
                        else
                        begin
                            top_reg <= top_reg - 1'b1;
                        end
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_addr_reg   <= res_grant_reg ? (base_reg + prod_reg) : '0;
                out_status_reg <= res_status_reg;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - ADDR_W - STATUS_W)'(0), out_status_reg, out_addr_reg};

endmodule

@@ design/fbpa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the fixed block pool allocator, bound to its top level.
// Depends on fbpa_pkg for the result field layout.
module fbpa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fbpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import fbpa_pkg::*;

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another was in flight");

    // Any failed request reports a zero address.
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[ADDR_W +: STATUS_W] != STAT_OK) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("failed request carries a nonzero address");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
